### hw/rtl/ydp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ydp_pkg
// Shared types and constants of the pixel-stream deinterlacer.
// ----------------------------------------------------------------------------
package ydp_pkg;

    // one column word carries five rows of 8-bit pixels, y-2 in the low byte
    localparam int PIX_W  = 8;
    localparam int NROWS  = 5;
    localparam int COL_W  = PIX_W * NROWS;

    // window of columns, the output column sits in the middle
    localparam int WIN    = 7;
    localparam int CENTER = 3;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE          = 2'd0,
        CFG_FIELD_PARITY  = 2'd1,
        CFG_TEMPORAL_PICK = 2'd2,
        CFG_FRAME_HEIGHT  = 2'd3
    } t_cfg_idx;

    typedef logic [COL_W-1:0] t_rows;

    // column of the three frames held by one window cell
    typedef struct packed {
        t_rows prv;
        t_rows cur;
        t_rows nxt;
    } t_col;

    // window cell control
    typedef struct packed {
        logic step;
        logic fill;
    } t_cell_ctl;

    // per-pixel flags that travel with a window position
    typedef struct packed {
        logic copy;
        logic bottom;
        logic line_last;
        logic frame_last;
    } t_tag;

endpackage

### hw/rtl/ydp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ydp_if
// Valid/ready stream interfaces for column words in and pixel words out.
// ----------------------------------------------------------------------------
interface ydp_in_if import ydp_pkg::*; ();
    logic  valid;
    logic  ready;
    t_rows prev_rows;
    t_rows cur_rows;
    t_rows next_rows;
    logic  line_end;

    modport source (output valid, prev_rows, cur_rows, next_rows, line_end, input ready);
    modport sink   (input valid, prev_rows, cur_rows, next_rows, line_end, output ready);
endinterface

interface ydp_out_if import ydp_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel;
    logic             is_line_last;
    logic             is_frame_last;

    modport source (output valid, pixel, is_line_last, is_frame_last, input ready);
    modport sink   (input valid, pixel, is_line_last, is_frame_last, output ready);
endinterface

### hw/rtl/ydp_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ydp_cell
// One window position: holds a column of the three frames and takes its
// neighbor's column on each step, or the broadcast column on a line start.
// ----------------------------------------------------------------------------
module ydp_cell import ydp_pkg::*; (
    input  logic      i_clk,
    input  t_cell_ctl i_ctl,
    input  t_col      i_fill,
    input  t_col      i_nbr,
    output t_col      o_col
);

    t_col r_col;

    // shift from the neighbor, or fill on the first column of a line
    always_ff @(posedge i_clk) begin
        if (i_ctl.step) begin
            if (i_ctl.fill) begin
                r_col <= i_fill;
            end else begin
                r_col <= i_nbr;
            end
        end
    end

    assign o_col = r_col;

endmodule

### hw/rtl/ydp_calc.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ydp_calc
// Three-stage pixel pipeline: diagonal scores and temporal terms, edge
// direction pick and band width, clamp into the output register.
// ----------------------------------------------------------------------------
module ydp_calc import ydp_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  t_tag             i_tag,
    input  t_rows            i_cur [WIN],
    input  t_rows            i_prev0,
    input  t_rows            i_next0,
    input  logic             i_skip_st,
    input  logic             i_tpick,
    output logic             o_ready,
    input  logic             i_out_ready,
    output logic             o_valid,
    output logic [PIX_W-1:0] o_pixel,
    output logic             o_line_last,
    output logic             o_frame_last
);

    localparam int NDG   = 5;
    localparam int DG_C  = 0;
    localparam int DG_M1 = 1;
    localparam int DG_M2 = 2;
    localparam int DG_P1 = 3;
    localparam int DG_P2 = 4;

    // byte k of a column, row y+2 repeats y+1 on the row above the bottom
    function automatic logic [PIX_W-1:0] rb(input t_rows v, input logic [2:0] k,
                                            input logic bt);
        logic [2:0] kk;
        kk = (k == 3'd4 && bt) ? 3'd3 : k;
        return v[PIX_W*kk +: PIX_W];
    endfunction

    function automatic logic [PIX_W-1:0] ad(input logic [PIX_W-1:0] a,
                                            input logic [PIX_W-1:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

    function automatic logic [PIX_W-1:0] avg(input logic [PIX_W-1:0] a,
                                             input logic [PIX_W-1:0] b);
        logic [PIX_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[PIX_W:1];
    endfunction

    function automatic logic [PIX_W+1:0] dsum3(
        input logic [PIX_W-1:0] a0, input logic [PIX_W-1:0] b0,
        input logic [PIX_W-1:0] a1, input logic [PIX_W-1:0] b1,
        input logic [PIX_W-1:0] a2, input logic [PIX_W-1:0] b2);
        return {2'b00, ad(a0, b0)} + {2'b00, ad(a1, b1)} + {2'b00, ad(a2, b2)};
    endfunction

    function automatic logic signed [PIX_W+1:0] smax(input logic signed [PIX_W+1:0] a,
                                                     input logic signed [PIX_W+1:0] b);
        return (a > b) ? a : b;
    endfunction

    function automatic logic signed [PIX_W+1:0] smin(input logic signed [PIX_W+1:0] a,
                                                     input logic signed [PIX_W+1:0] b);
        return (a < b) ? a : b;
    endfunction

    // stage enables, a stage moves when the one after it can take a word
    logic mv1, mv2, mv3;
    logic r1_valid, r2_valid;

    assign mv3     = !o_valid || i_out_ready;
    assign mv2     = !r2_valid || mv3;
    assign mv1     = !r1_valid || mv2;
    assign o_ready = mv1;

    // ---------------- stage 1: scores, candidates, temporal terms ----------
    logic [PIX_W-1:0]         up [WIN];
    logic [PIX_W-1:0]         dn [WIN];
    t_rows                    p2, n2;
    logic [PIX_W-1:0]         c, e, d, td0, td1, td2, bb, ff, diff0;
    logic [PIX_W:0]           t1s, t2s;
    logic signed [PIX_W+1:0]  de, dc, bc, fe, mx, mn;
    logic [PIX_W+1:0]         ds [NDG];
    logic [PIX_W-1:0]         sp [NDG];

    always_comb begin
        for (int i = 0; i < WIN; i++) begin
            up[i] = i_cur[i][2*PIX_W-1:PIX_W];
            dn[i] = i_cur[i][4*PIX_W-1:3*PIX_W];
        end
        p2 = i_tpick ? i_prev0 : i_cur[CENTER];
        n2 = i_tpick ? i_cur[CENTER] : i_next0;
        c  = up[CENTER];
        e  = dn[CENTER];
        d  = avg(rb(p2, 3'd2, i_tag.bottom), rb(n2, 3'd2, i_tag.bottom));
        td0 = ad(rb(p2, 3'd2, i_tag.bottom), rb(n2, 3'd2, i_tag.bottom));
        t1s = {1'b0, ad(rb(i_prev0, 3'd1, i_tag.bottom), c)}
            + {1'b0, ad(rb(i_prev0, 3'd3, i_tag.bottom), e)};
        t2s = {1'b0, ad(rb(i_next0, 3'd1, i_tag.bottom), c)}
            + {1'b0, ad(rb(i_next0, 3'd3, i_tag.bottom), e)};
        td1 = t1s[PIX_W:1];
        td2 = t2s[PIX_W:1];
        diff0 = {1'b0, td0[PIX_W-1:1]};
        if (td1 > diff0) begin
            diff0 = td1;
        end
        if (td2 > diff0) begin
            diff0 = td2;
        end

        // spatial-temporal bounds
        bb = avg(rb(p2, 3'd0, i_tag.bottom), rb(n2, 3'd0, i_tag.bottom));
        ff = avg(rb(p2, 3'd4, i_tag.bottom), rb(n2, 3'd4, i_tag.bottom));
        de = $signed({2'b00, d}) - $signed({2'b00, e});
        dc = $signed({2'b00, d}) - $signed({2'b00, c});
        bc = $signed({2'b00, bb}) - $signed({2'b00, c});
        fe = $signed({2'b00, ff}) - $signed({2'b00, e});
        mx = smax(smax(de, dc), smin(bc, fe));
        mn = smin(smin(de, dc), smax(bc, fe));

        // diagonal scores and their interpolated values
        ds[DG_C]  = dsum3(up[2], dn[2], up[3], dn[3], up[4], dn[4]);
        ds[DG_M1] = dsum3(up[1], dn[3], up[2], dn[4], up[3], dn[5]);
        ds[DG_M2] = dsum3(up[0], dn[4], up[1], dn[5], up[2], dn[6]);
        ds[DG_P1] = dsum3(up[3], dn[1], up[4], dn[2], up[5], dn[3]);
        ds[DG_P2] = dsum3(up[4], dn[0], up[5], dn[1], up[6], dn[2]);
        sp[DG_C]  = avg(up[3], dn[3]);
        sp[DG_M1] = avg(up[2], dn[4]);
        sp[DG_M2] = avg(up[1], dn[5]);
        sp[DG_P1] = avg(up[4], dn[2]);
        sp[DG_P2] = avg(up[5], dn[1]);
    end

    logic                    r1_copy, r1_ll, r1_fl;
    logic [PIX_W-1:0]        r1_cpx, r1_d, r1_diff0;
    logic signed [PIX_W+1:0] r1_mx, r1_mn;
    logic [PIX_W+1:0]        r1_ds [NDG];
    logic [PIX_W-1:0]        r1_sp [NDG];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (mv1) begin
            r1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mv1) begin
            r1_copy  <= i_tag.copy;
            r1_ll    <= i_tag.line_last;
            r1_fl    <= i_tag.frame_last;
            r1_cpx   <= i_cur[CENTER][3*PIX_W-1:2*PIX_W];
            r1_d     <= d;
            r1_diff0 <= diff0;
            r1_mx    <= mx;
            r1_mn    <= mn;
            for (int i = 0; i < NDG; i++) begin
                r1_ds[i] <= ds[i];
                r1_sp[i] <= sp[i];
            end
        end
    end

    // ---------------- stage 2: edge direction and band width --------------
    logic signed [PIX_W+2:0] sc, dd, mn_x, mx_n;
    logic [PIX_W-1:0]        sp_sel;

    always_comb begin
        sc     = $signed({1'b0, r1_ds[DG_C]}) - 11'sd1;
        sp_sel = r1_sp[DG_C];
        // left-leaning diagonals, the steeper one only if the first wins
        if ($signed({1'b0, r1_ds[DG_M1]}) < sc) begin
            sc     = $signed({1'b0, r1_ds[DG_M1]});
            sp_sel = r1_sp[DG_M1];
            if ($signed({1'b0, r1_ds[DG_M2]}) < sc) begin
                sc     = $signed({1'b0, r1_ds[DG_M2]});
                sp_sel = r1_sp[DG_M2];
            end
        end
        // right-leaning diagonals
        if ($signed({1'b0, r1_ds[DG_P1]}) < sc) begin
            sc     = $signed({1'b0, r1_ds[DG_P1]});
            sp_sel = r1_sp[DG_P1];
            if ($signed({1'b0, r1_ds[DG_P2]}) < sc) begin
                sc     = $signed({1'b0, r1_ds[DG_P2]});
                sp_sel = r1_sp[DG_P2];
            end
        end

        // widen the temporal band unless the check is skipped
        mn_x = {r1_mn[PIX_W+1], r1_mn};
        mx_n = 11'sd0 - {r1_mx[PIX_W+1], r1_mx};
        dd   = $signed({3'b000, r1_diff0});
        if (!i_skip_st) begin
            if (mn_x > dd) begin
                dd = mn_x;
            end
            if (mx_n > dd) begin
                dd = mx_n;
            end
        end
    end

    logic             r2_copy, r2_ll, r2_fl;
    logic [PIX_W-1:0] r2_cpx, r2_d, r2_diff, r2_sp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (mv2) begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mv2) begin
            r2_copy <= r1_copy;
            r2_ll   <= r1_ll;
            r2_fl   <= r1_fl;
            r2_cpx  <= r1_cpx;
            r2_d    <= r1_d;
            r2_diff <= dd[PIX_W-1:0];
            r2_sp   <= sp_sel;
        end
    end

    // ---------------- stage 3: clamp into the output register -------------
    logic [PIX_W:0]          hi;
    logic signed [PIX_W+1:0] lo;
    logic [PIX_W-1:0]        n_pixel;

    always_comb begin
        hi = {1'b0, r2_d} + {1'b0, r2_diff};
        lo = $signed({2'b00, r2_d}) - $signed({2'b00, r2_diff});
        if (r2_copy) begin
            n_pixel = r2_cpx;
        end else if ({1'b0, r2_sp} > hi) begin
            n_pixel = hi[PIX_W-1:0];
        end else if ($signed({2'b00, r2_sp}) < lo) begin
            n_pixel = lo[PIX_W-1:0];
        end else begin
            n_pixel = r2_sp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (mv3) begin
            o_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mv3) begin
            o_pixel      <= n_pixel;
            o_line_last  <= r2_ll;
            o_frame_last <= r2_fl;
        end
    end

endmodule

### hw/rtl/yadif_deinterlace_pixel.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yadif_deinterlace_pixel
// Pixel-stream deinterlacer for one plane: copies the kept field, rebuilds
// the other by edge-directed interpolation held in a temporal band.
// ----------------------------------------------------------------------------
// Usage
//   i_pix takes one column word per pixel in raster order: five rows
//   (y-2..y+2) of the previous, current and next frames, plus line_end on
//   the last column of each line. o_pix gives one pixel word per column
//   with line and frame end flags.
//   A seven-cell window of columns shifts once per accepted word; the pixel
//   of column x leaves with column x+3, passing from the window through the
//   score stage, the select stage and the output register.
//   Throughput is one column per cycle inside a line while the receiver
//   keeps up; the word carrying line_end holds the input off while the
//   window shifts the last column in again in ST_FL1, ST_FL2 and ST_FL3.
//   Reset empties the pipeline, clears the counters and loads the register
//   defaults; the window needs no clearing since a line start refills it.
//   A stalled receiver backs up the output register, two stage registers
//   and the window position; input keeps flowing until those are full.
//   Configuration writes go on i_cfg_we/i_cfg_idx/i_cfg_data while idle.
// ----------------------------------------------------------------------------
module yadif_deinterlace_pixel import ydp_pkg::*; #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    ydp_in_if.sink                i_pix,
    ydp_out_if.source             o_pix,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int CNT_W = $clog2(MAX_WIDTH + 1);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam int HT_W  = ((CFG_DATA_W > ROW_W) ? CFG_DATA_W : ROW_W) + 1;

    typedef enum logic [3:0] {
        ST_RUN = 4'b0001,
        ST_FL1 = 4'b0010,
        ST_FL2 = 4'b0100,
        ST_FL3 = 4'b1000
    } t_fsm;

    // configuration registers
    logic [1:0]            r_mode;
    logic                  r_fpar;
    logic                  r_tpick;
    logic [CFG_DATA_W-1:0] r_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= 2'd0;
            r_fpar   <= 1'b0;
            r_tpick  <= 1'b1;
            r_height <= CFG_DATA_W'(480);
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_MODE: begin
                    r_mode <= i_cfg_data[1:0];
                end
                CFG_FIELD_PARITY: begin
                    r_fpar <= i_cfg_data[0];
                end
                CFG_TEMPORAL_PICK: begin
                    r_tpick <= i_cfg_data[0];
                end
                CFG_FRAME_HEIGHT: begin
                    r_height <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    // control state
    t_fsm             r_state, n_state;
    logic [CNT_W-1:0] r_col_cnt, n_col_cnt;
    logic [ROW_W-1:0] r_row, n_row;
    logic [1:0]       r_fcol, n_fcol;
    logic             r_fend, n_fend;
    logic             r_w_valid, n_w_valid;
    t_tag             r_w_tag, n_w_tag;

    logic             calc_rdy;
    logic             w_move, in_rdy, in_acc, fl_step;
    t_cell_ctl        cell_ctl;

    // window advances when its current position is taken or needs no pixel
    assign w_move      = !r_w_valid || calc_rdy;
    assign in_rdy      = (r_state == ST_RUN) && w_move;
    assign i_pix.ready = in_rdy;
    assign in_acc      = i_pix.valid && in_rdy;
    assign fl_step     = (r_state != ST_RUN) && w_move;
    assign cell_ctl.step = in_acc || fl_step;
    assign cell_ctl.fill = in_acc && (r_col_cnt == '0);

    // row classification
    logic [HT_W-1:0] eff_h, y;
    logic            row_copy, row_bottom, row_last;

    always_comb begin
        eff_h = (HT_W'(r_height) > HT_W'(MAX_HEIGHT)) ? HT_W'(MAX_HEIGHT) : HT_W'(r_height);
        y     = HT_W'(r_row);
        row_last   = (y + HT_W'(1)) >= eff_h;
        row_bottom = (y + HT_W'(2)) >= eff_h;
        row_copy   = (y < HT_W'(2)) || row_last || (r_row[0] == r_fpar);
    end

    // sequencer: accept columns, then three flush steps at line end
    always_comb begin
        n_state   = r_state;
        n_col_cnt = r_col_cnt;
        n_row     = r_row;
        n_fcol    = r_fcol;
        n_fend    = r_fend;
        n_w_valid = w_move ? 1'b0 : r_w_valid;
        n_w_tag   = r_w_tag;
        if (cell_ctl.step) begin
            n_w_tag.copy       = row_copy;
            n_w_tag.bottom     = row_bottom;
            n_w_tag.line_last  = 1'b0;
            n_w_tag.frame_last = 1'b0;
        end
        case (r_state)
            ST_RUN: begin
                if (in_acc) begin
                    n_w_valid = (r_col_cnt >= CNT_W'(3));
                    if (i_pix.line_end) begin
                        n_state   = ST_FL1;
                        n_col_cnt = '0;
                        n_fcol    = (r_col_cnt >= CNT_W'(3)) ? 2'd3 : r_col_cnt[1:0];
                        n_fend    = row_last;
                    end else if (r_col_cnt < CNT_W'(MAX_WIDTH)) begin
                        n_col_cnt = r_col_cnt + CNT_W'(1);
                    end
                end
            end
            ST_FL1: begin
                if (fl_step) begin
                    n_w_valid = (r_fcol >= 2'd2);
                    n_state   = ST_FL2;
                end
            end
            ST_FL2: begin
                if (fl_step) begin
                    n_w_valid = (r_fcol != 2'd0);
                    n_state   = ST_FL3;
                end
            end
            ST_FL3: begin
                if (fl_step) begin
                    n_w_valid          = 1'b1;
                    n_w_tag.line_last  = 1'b1;
                    n_w_tag.frame_last = r_fend;
                    n_state            = ST_RUN;
                    n_row              = r_fend ? '0 : r_row + ROW_W'(1);
                end
            end
            default: begin
                n_state = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_RUN;
            r_col_cnt <= '0;
            r_row     <= '0;
            r_fcol    <= 2'd0;
            r_fend    <= 1'b0;
            r_w_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_col_cnt <= n_col_cnt;
            r_row     <= n_row;
            r_fcol    <= n_fcol;
            r_fend    <= n_fend;
            r_w_valid <= n_w_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_w_tag <= n_w_tag;
    end

    // window: row of cells, the top cell re-takes its own column on flush
    t_col  in_col;
    t_col  win [WIN];
    t_rows cur_cols [WIN];

    assign in_col.prv = i_pix.prev_rows;
    assign in_col.cur = i_pix.cur_rows;
    assign in_col.nxt = i_pix.next_rows;

    for (genvar g = 0; g < WIN; g++) begin : g_cell
        t_col nbr;
        if (g == WIN - 1) begin : g_top
            assign nbr = (r_state == ST_RUN) ? in_col : win[g];
        end else begin : g_mid
            assign nbr = win[g+1];
        end
        ydp_cell u_cell (
            .i_clk  (i_clk),
            .i_ctl  (cell_ctl),
            .i_fill (in_col),
            .i_nbr  (nbr),
            .o_col  (win[g])
        );
        assign cur_cols[g] = win[g].cur;
    end

    // pixel pipeline
    ydp_calc u_calc (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (r_w_valid),
        .i_tag        (r_w_tag),
        .i_cur        (cur_cols),
        .i_prev0      (win[CENTER].prv),
        .i_next0      (win[CENTER].nxt),
        .i_skip_st    (r_mode[1]),
        .i_tpick      (r_tpick),
        .o_ready      (calc_rdy),
        .i_out_ready  (o_pix.ready),
        .o_valid      (o_pix.valid),
        .o_pixel      (o_pix.pixel),
        .o_line_last  (o_pix.is_line_last),
        .o_frame_last (o_pix.is_frame_last)
    );

endmodule

### hw/rtl/ydp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ydp_checker
// Port-level checks of the deinterlacer streams, bound to the top level.
// ----------------------------------------------------------------------------
module ydp_checker import ydp_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             i_in_ready,
    input logic             i_in_last,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input logic [PIX_W-1:0] i_pixel,
    input logic             i_line_last,
    input logic             i_frame_last
);

    // a stalled output word stays up
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("output word dropped while stalled");

    // and keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            ($stable(i_pixel) && $stable(i_line_last) && $stable(i_frame_last)))
        else $error("output word changed while stalled");

    // reset empties the pipeline
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid right after reset");

    // line end is followed by the flush, during which no input is taken
    a_flush_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && i_in_last) |=>
            (!i_in_ready ##1 !i_in_ready ##1 !i_in_ready))
        else $error("input taken during line flush");

endmodule

bind yadif_deinterlace_pixel ydp_checker u_ydp_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_pix.valid),
    .i_in_ready   (i_pix.ready),
    .i_in_last    (i_pix.line_end),
    .i_out_valid  (o_pix.valid),
    .i_out_ready  (o_pix.ready),
    .i_pixel      (o_pix.pixel),
    .i_line_last  (o_pix.is_line_last),
    .i_frame_last (o_pix.is_frame_last)
);

### test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the pixel-stream deinterlacer. Column words go in
// line by line over small frames; a scoreboard keeps its own copy of the
// window, the counters and the registers, works out the pixel words each
// accepted column causes and checks every output word against the oldest
// one. Both handshake sides idle in random bursts; settings change between
// lines while the block is idle.
// ----------------------------------------------------------------------------
module tb_top import ydp_pkg::*; ();

    // narrow column counter so that the long line saturates it quickly
    localparam int MAX_W         = 16;
    localparam int MAX_H         = 4096;
    localparam int RANDOM_WORDS  = 200;
    localparam int CALM_WORDS    = 40;
    localparam int LONG_LINE     = MAX_W + 4;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 300000;
    localparam int PRINT_CAP     = 100;

    // content shape of a line
    typedef enum int {
        FILL_RANDOM,
        FILL_SMOOTH,
        FILL_EXTREME
    } fill_style_t;

    // one pixel word as it leaves the block
    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             line_last;
        logic             frame_last;
    } out_word_t;

    // scoreboard: shadow window and counters, queue of expected pixel words
    class deint_scoreboard;
        logic [1:0]            mode;
        logic                  parity;
        logic                  pick;
        logic [CFG_DATA_W-1:0] height;
        t_rows                 cur_win [WIN];
        t_rows                 prv_dly [4];
        t_rows                 nxt_dly [4];
        int unsigned           col_cnt;
        int unsigned           row_cnt;
        out_word_t             expected_pixels [$];
        int                    errors;

        function new();
            mode    = 2'd0;
            parity  = 1'b0;
            pick    = 1'b1;
            height  = 13'd480;
            col_cnt = 0;
            row_cnt = 0;
            errors  = 0;
            load_window('0, '0, '0);
        endfunction

        function int pending();
            return expected_pixels.size();
        endfunction

        function void set_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_MODE:          mode   = data[1:0];
                CFG_FIELD_PARITY:  parity = data[0];
                CFG_TEMPORAL_PICK: pick   = data[0];
                CFG_FRAME_HEIGHT:  height = data;
                default: ;
            endcase
        endfunction

        function int unsigned eff_height();
            return (height > MAX_H) ? MAX_H : height;
        endfunction

        // first column of a line fills every cell
        function void load_window(t_rows c, t_rows p, t_rows n);
            for (int i = 0; i < WIN; i++) cur_win[i] = c;
            for (int i = 0; i < 4; i++) begin
                prv_dly[i] = p;
                nxt_dly[i] = n;
            end
        endfunction

        function void shift_window(t_rows c, t_rows p, t_rows n);
            for (int i = 0; i < WIN - 1; i++) cur_win[i] = cur_win[i + 1];
            cur_win[WIN - 1] = c;
            for (int i = 0; i < 3; i++) begin
                prv_dly[i] = prv_dly[i + 1];
                nxt_dly[i] = nxt_dly[i + 1];
            end
            prv_dly[3] = p;
            nxt_dly[3] = n;
        endfunction

        function int iabs(int v);
            return (v < 0) ? -v : v;
        endfunction

        function int imax(int a, int b);
            return (a > b) ? a : b;
        endfunction

        function int imin(int a, int b);
            return (a < b) ? a : b;
        endfunction

        // row k of a column; above the bottom row, y+2 repeats y+1
        function int px(t_rows v, int k, bit bottom);
            if (k == 4 && bottom) k = 3;
            return int'(v[PIX_W*k +: PIX_W]);
        endfunction

        function int diag_score(int j, bit bottom);
            return iabs(px(cur_win[2 + j], 1, bottom) - px(cur_win[2 - j], 3, bottom))
                 + iabs(px(cur_win[3 + j], 1, bottom) - px(cur_win[3 - j], 3, bottom))
                 + iabs(px(cur_win[4 + j], 1, bottom) - px(cur_win[4 - j], 3, bottom));
        endfunction

        // pixel of the center column: copied or interpolated
        function logic [PIX_W-1:0] predict_pixel();
            int unsigned y;
            int unsigned h;
            bit          bottom;
            t_rows       p2;
            t_rows       n2;
            int          c, d, e, td0, td1, td2, diff, sp, score, s, b, f, mx, mn;
            y = row_cnt;
            h = eff_height();
            if (y < 2 || y + 1 >= h || y[0] == parity)
                return cur_win[CENTER][2*PIX_W +: PIX_W];

            bottom = (y + 2 >= h);
            p2 = pick ? prv_dly[0] : cur_win[CENTER];
            n2 = pick ? cur_win[CENTER] : nxt_dly[0];

            c   = px(cur_win[CENTER], 1, bottom);
            e   = px(cur_win[CENTER], 3, bottom);
            d   = (px(p2, 2, bottom) + px(n2, 2, bottom)) >> 1;
            td0 = iabs(px(p2, 2, bottom) - px(n2, 2, bottom));
            td1 = (iabs(px(prv_dly[0], 1, bottom) - c)
                 + iabs(px(prv_dly[0], 3, bottom) - e)) >> 1;
            td2 = (iabs(px(nxt_dly[0], 1, bottom) - c)
                 + iabs(px(nxt_dly[0], 3, bottom) - e)) >> 1;
            diff = imax(imax(td0 >> 1, td1), td2);

            // edge-directed spatial guess, the outer diagonal only after the inner
            sp    = (c + e) >> 1;
            score = diag_score(0, bottom) - 1;
            s = diag_score(-1, bottom);
            if (s < score) begin
                score = s;
                sp = (px(cur_win[2], 1, bottom) + px(cur_win[4], 3, bottom)) >> 1;
                s = diag_score(-2, bottom);
                if (s < score) begin
                    score = s;
                    sp = (px(cur_win[1], 1, bottom) + px(cur_win[5], 3, bottom)) >> 1;
                end
            end
            s = diag_score(1, bottom);
            if (s < score) begin
                score = s;
                sp = (px(cur_win[4], 1, bottom) + px(cur_win[2], 3, bottom)) >> 1;
                s = diag_score(2, bottom);
                if (s < score) begin
                    score = s;
                    sp = (px(cur_win[5], 1, bottom) + px(cur_win[1], 3, bottom)) >> 1;
                end
            end

            // spatial-temporal widening of the band
            if (mode[1] == 1'b0) begin
                b  = (px(p2, 0, bottom) + px(n2, 0, bottom)) >> 1;
                f  = (px(p2, 4, bottom) + px(n2, 4, bottom)) >> 1;
                mx = imax(imax(d - e, d - c), imin(b - c, f - e));
                mn = imin(imin(d - e, d - c), imax(b - c, f - e));
                diff = imax(imax(diff, mn), -mx);
            end

            if (sp > d + diff)
                sp = d + diff;
            else if (sp < d - diff)
                sp = d - diff;
            return sp[PIX_W-1:0];
        endfunction

        function void expect_pixel(bit line_last, bit frame_last);
            out_word_t w;
            w.pixel      = predict_pixel();
            w.line_last  = line_last;
            w.frame_last = frame_last;
            expected_pixels.push_back(w);
        endfunction

        // accepted column word: advance the window, queue the pixels it causes
        function void note_column(t_rows p, t_rows c, t_rows n, logic last);
            int unsigned colv;
            bit          frame_end;
            colv = col_cnt;
            if (colv == 0)
                load_window(c, p, n);
            else
                shift_window(c, p, n);
            if (colv >= 3)
                expect_pixel(1'b0, 1'b0);
            if (last) begin
                frame_end = (row_cnt + 1 >= eff_height());
                // right edge: last column shifted in again
                for (int k = 1; k <= 3; k++) begin
                    shift_window(cur_win[WIN - 1], prv_dly[3], nxt_dly[3]);
                    if (colv + k >= 3)
                        expect_pixel(k == 3, k == 3 && frame_end);
                end
                row_cnt = frame_end ? 0 : row_cnt + 1;
                col_cnt = 0;
            end else if (colv < MAX_W) begin
                col_cnt = colv + 1;
            end
        endfunction

        task report(string msg);
            errors++;
            if (errors <= PRINT_CAP)
                $display("MISMATCH: %s", msg);
        endtask

        task check_pixel(logic [PIX_W-1:0] pix, logic line_last, logic frame_last);
            out_word_t want;
            if (expected_pixels.size() == 0) begin
                report($sformatf("pixel word %02h with none expected", pix));
                return;
            end
            want = expected_pixels.pop_front();
            if (pix !== want.pixel)
                report($sformatf("pixel %02h, expected %02h", pix, want.pixel));
            if (line_last !== want.line_last)
                report($sformatf("is_line_last %b, expected %b", line_last, want.line_last));
            if (frame_last !== want.frame_last)
                report($sformatf("is_frame_last %b, expected %b", frame_last,
                                 want.frame_last));
        endtask
    endclass

    // clock, reset and driven signals, all known from time zero
    logic                  i_clk    = 1'b0;
    logic                  i_rst_n  = 1'b0;
    logic                  tx_valid = 1'b0;
    t_rows                 tx_prev  = '0;
    t_rows                 tx_cur   = '0;
    t_rows                 tx_next  = '0;
    logic                  tx_last  = 1'b0;
    logic                  rx_ready = 1'b0;
    logic                  cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    bit              gaps_on     = 1'b1;
    bit              calm        = 1'b0;
    int              rx_stall    = 0;
    int              cycle_count = 0;
    int              words_sent  = 0;
    deint_scoreboard sb;

    ydp_in_if  pix_in ();
    ydp_out_if pix_out ();

    assign pix_in.valid     = tx_valid;
    assign pix_in.prev_rows = tx_prev;
    assign pix_in.cur_rows  = tx_cur;
    assign pix_in.next_rows = tx_next;
    assign pix_in.line_end  = tx_last;
    assign pix_out.ready    = rx_ready;

    yadif_deinterlace_pixel #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pix      (pix_in),
        .o_pix      (pix_out),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // receiver: check each accepted pixel word, stall in bursts
    always @(posedge i_clk) begin
        if (i_rst_n && pix_out.valid && pix_out.ready)
            sb.check_pixel(pix_out.pixel, pix_out.is_line_last, pix_out.is_frame_last);
        if (rx_stall > 0) begin
            rx_stall <= rx_stall - 1;
            rx_ready <= 1'b0;
        end else if (gaps_on && !calm && $urandom_range(0, 5) == 0) begin
            rx_stall <= $urandom_range(0, 15);
            rx_ready <= 1'b0;
        end else begin
            rx_ready <= 1'b1;
        end
    end

    function automatic t_rows make_rows(fill_style_t style, int base);
        t_rows v;
        int    b;
        for (int k = 0; k < NROWS; k++) begin
            case (style)
                FILL_RANDOM: b = $urandom_range(0, 255);
                FILL_SMOOTH: b = base + int'($urandom_range(0, 16)) - 8;
                default:     b = $urandom_range(0, 1) ? 255 : 0;
            endcase
            if (b < 0) b = 0;
            if (b > 255) b = 255;
            v[PIX_W*k +: PIX_W] = b[PIX_W-1:0];
        end
        return v;
    endfunction

    function automatic int pick_width();
        case ($urandom_range(0, 9))
            0, 1:    return $urandom_range(1, 3);
            2:       return $urandom_range(13, 40);
            default: return $urandom_range(4, 12);
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_height();
        case ($urandom_range(0, 9))
            0:       return CFG_DATA_W'(MAX_H);
            default: return CFG_DATA_W'($urandom_range(3, 9));
        endcase
    endfunction

    // one column word, with an optional idle burst in front
    task automatic send_word(t_rows p, t_rows c, t_rows n, logic last);
        int gap;
        if (gaps_on && !calm && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 16);
            tx_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        tx_valid <= 1'b1;
        tx_prev  <= p;
        tx_cur   <= c;
        tx_next  <= n;
        tx_last  <= last;
        do @(posedge i_clk); while (!pix_in.ready);
        sb.note_column(p, c, n, last);
        words_sent++;
    endtask

    // hold the input off until every expected pixel word is out
    task automatic drain();
        tx_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    task automatic settle();
        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic send_line(int width, fill_style_t style, int hold_at);
        int base;
        base = $urandom_range(0, 255);
        for (int i = 0; i < width; i++) begin
            if (i == hold_at)
                drain();
            send_word(make_rows(style, base), make_rows(style, base),
                      make_rows(style, base), i == width - 1);
        end
    endtask

    task automatic put_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge i_clk);
        sb.set_reg(idx, data);
    endtask

    task automatic write_regs(logic [1:0] m, logic par, logic pk, logic [CFG_DATA_W-1:0] h);
        put_reg(CFG_MODE, CFG_DATA_W'(m));
        put_reg(CFG_FIELD_PARITY, CFG_DATA_W'(par));
        put_reg(CFG_TEMPORAL_PICK, CFG_DATA_W'(pk));
        put_reg(CFG_FRAME_HEIGHT, h);
        cfg_we <= 1'b0;
    endtask

    initial begin
        int phase;
        int target;
        sb = new();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // five-row frame: tiny lines at the top, interpolated row above the bottom,
        // input held off mid-line until the output is empty
        write_regs(2'd0, 1'b0, 1'b1, 13'd5);
        send_word('1, '1, '1, 1'b1);
        send_word('0, '0, '0, 1'b0);
        send_word('0, '0, '0, 1'b1);
        send_line(3, FILL_RANDOM, -1);
        send_line(8, FILL_EXTREME, 5);
        send_line(4, FILL_RANDOM, -1);

        // other parity, next frame as partner, no spatial-temporal check
        settle();
        write_regs(2'd2, 1'b1, 1'b0, 13'd6);
        send_line(1, FILL_SMOOTH, -1);
        send_line(1, FILL_SMOOTH, -1);
        send_line(4, FILL_RANDOM, -1);

        // random phases; first ones pin the extremes
        phase  = 0;
        target = words_sent + RANDOM_WORDS;
        while (words_sent < target) begin
            settle();
            case (phase)
                0:       write_regs(2'd3, 1'b1, 1'b0, 13'(MAX_H));
                1:       write_regs(2'd0, 1'b0, 1'b1, 13'd3);
                2:       write_regs(2'd1, 1'b1, 1'b1, 13'h1FFF);
                3:       write_regs(2'd2, 1'b0, 1'b0, 13'd7);
                default: write_regs(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                                    1'($urandom_range(0, 1)), pick_height());
            endcase
            gaps_on = ($urandom_range(0, 3) != 0);
            if (target - words_sent <= CALM_WORDS)
                calm = 1'b1;
            repeat ($urandom_range(2, 6))
                send_line(pick_width(), fill_style_t'($urandom_range(0, 2)), -1);
            phase++;
        end

        // line longer than the column counter's range, then a normal one
        calm = 1'b1;
        send_line(LONG_LINE, FILL_RANDOM, -1);
        send_line(5, FILL_SMOOTH, -1);

        settle();
        if (sb.pending() != 0)
            sb.report($sformatf("%0d pixel words never came", sb.pending()));
        if (sb.errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
